/* sv/fsga_pkg.sv */
// Shared types, codes and default sizes for the forest fire grid automaton.
package fsga_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Field widths of the stream payloads and configuration registers.
  localparam int OP_W     = 2;
  localparam int POS_W    = 6;
  localparam int CELL_W   = 2;
  localparam int DIM_W    = 7;
  localparam int WIND_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam logic [CELL_W-1:0] CELL_EMPTY = 2'd0;
  localparam logic [CELL_W-1:0] CELL_TREE  = 2'd1;
  localparam logic [CELL_W-1:0] CELL_FIRE  = 2'd2;
  localparam logic [CELL_W-1:0] CELL_BURNT = 2'd3;

  localparam logic [WIND_W-1:0] WIND_ALL   = 3'd0;
  localparam logic [WIND_W-1:0] WIND_UP    = 3'd1;
  localparam logic [WIND_W-1:0] WIND_DOWN  = 3'd2;
  localparam logic [WIND_W-1:0] WIND_LEFT  = 3'd3;
  localparam logic [WIND_W-1:0] WIND_RIGHT = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIND_MODE = 2'd2;

  localparam logic [DIM_W-1:0]  RST_GRID_ROWS = 7'd64;
  localparam logic [DIM_W-1:0]  RST_GRID_COLS = 7'd64;
  localparam logic [WIND_W-1:0] RST_WIND_MODE = WIND_ALL;

  typedef enum logic [8:0] {
    ST_CLEAR   = 9'b000000001,
    ST_IDLE    = 9'b000000010,
    ST_ACCESS  = 9'b000000100,
    ST_ADV_LD1 = 9'b000001000,
    ST_ADV_LD2 = 9'b000010000,
    ST_ADV_ROW = 9'b000100000,
    ST_ADV_CNT = 9'b001000000,
    ST_RESULT  = 9'b010000000,
    ST_SPARE   = 9'b100000000
  } state_t;

endpackage

/* sv/fire_spread_grid_automaton.sv */
// Forest fire automaton: row-wide grid memory with a sliding three-row generation window.
// An in-range write or read does one memory read in the access state before its result is given.
// An advance loads the first two rows, then for each row writes the next generation and
// counts its burning cells one column a cycle.
// One transaction is in progress at a time; a pending result register lets the next one in.
// After reset a clearing pass zeroes every grid row before any input is accepted.
module fire_spread_grid_automaton
  import fsga_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // op[1:0], row[7:2], col[13:8], cell_value[15:14]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // read_value[1:0], any_burning[2], zero padding[7:3]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [DIM_W-1:0]      cfg_wdata
);

  localparam int RAW   = $clog2(MAX_ROWS);
  localparam int CAW   = $clog2(MAX_COLS);
  localparam int ROW_W = MAX_COLS * CELL_W;
  localparam int CNT_W = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam logic [RAW-1:0] LAST_ROW = RAW'(MAX_ROWS - 1);
  localparam logic [CAW-1:0] LAST_COL = CAW'(MAX_COLS - 1);

  // Grid storage, one row of cells per entry.
  logic [ROW_W-1:0] grid_mem [MAX_ROWS];
  logic [ROW_W-1:0] rd_data_r;
  logic             mem_we;
  logic             mem_re;
  logic [RAW-1:0]   mem_waddr;
  logic [RAW-1:0]   mem_raddr;
  logic [ROW_W-1:0] mem_wdata;

  state_t           state_r,     state_nxt;
  logic [RAW-1:0]   row_r,       row_nxt;
  logic [CAW-1:0]   colc_r,      colc_nxt;
  logic [ROW_W-1:0] prev_row_r,  prev_row_nxt;
  logic [ROW_W-1:0] cur_row_r,   cur_row_nxt;
  logic [ROW_W-1:0] next_row_r,  next_row_nxt;
  logic [ROW_W-1:0] shift_r,     shift_nxt;
  logic [CNT_W-1:0] cnt_r,       cnt_nxt;
  op_t              op_r,        op_nxt;
  logic [POS_W-1:0] item_row_r,  item_row_nxt;
  logic [POS_W-1:0] item_col_r,  item_col_nxt;
  logic [CELL_W-1:0] item_val_r, item_val_nxt;
  logic [CELL_W-1:0] rdval_r,    rdval_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0] out_rd_r,   out_rd_nxt;
  logic             out_any_r,   out_any_nxt;
  logic [DIM_W-1:0] grid_rows_r, grid_rows_nxt;
  logic [DIM_W-1:0] grid_cols_r, grid_cols_nxt;
  logic [WIND_W-1:0] wind_r,     wind_nxt;

  logic [POS_W-1:0]  in_row;
  logic [POS_W-1:0]  in_col;
  logic [CELL_W-1:0] in_val;
  op_t               in_op;
  logic              in_inside;
  logic [CAW-1:0]    cidx;
  logic [CELL_W-1:0] old_cell;
  logic [ROW_W-1:0]  mod_row;
  logic [ROW_W-1:0]  new_row;
  logic [RAW:0]      row_p1;
  logic [RAW:0]      row_p2;
  logic              row_in_area;
  logic              up_in;
  logic              dn_in;
  logic              up_ok;
  logic              down_ok;
  logic              left_ok;
  logic              right_ok;
  logic [ROW_W+3:0]  cur_ext;

  assign in_op  = op_t'(in_tdata[OP_W-1:0]);
  assign in_row = in_tdata[OP_W +: POS_W];
  assign in_col = in_tdata[OP_W+POS_W +: POS_W];
  assign in_val = in_tdata[OP_W+2*POS_W +: CELL_W];
  assign in_inside = (in_row < MAX_ROWS) && (in_col < MAX_COLS);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - CELL_W - 1)'(0), out_any_r, out_rd_r};

  // Cell addressed by the current read or write transaction.
  assign cidx     = CAW'(item_col_r);
  assign old_cell = rd_data_r[cidx*CELL_W +: CELL_W];
  always_comb begin
    mod_row = rd_data_r;
    mod_row[cidx*CELL_W +: CELL_W] = item_val_r;
  end

  // Window of old rows around row_r; the padding cells at both ends never burn.
  assign row_p1      = {1'b0, row_r} + (RAW+1)'(1);
  assign row_p2      = {1'b0, row_r} + (RAW+1)'(2);
  assign row_in_area = row_r < grid_rows_r;
  assign up_in       = row_r != '0;
  assign dn_in       = (row_p1 < grid_rows_r) && (row_p1 < MAX_ROWS);
  assign up_ok       = (wind_r == WIND_ALL) || (wind_r == WIND_UP);
  assign down_ok     = (wind_r == WIND_ALL) || (wind_r == WIND_DOWN);
  assign left_ok     = (wind_r == WIND_ALL) || (wind_r == WIND_LEFT);
  assign right_ok    = (wind_r == WIND_ALL) || (wind_r == WIND_RIGHT);
  assign cur_ext     = {CELL_EMPTY, cur_row_r, CELL_EMPTY};

  always_comb begin
    new_row = cur_row_r;
    for (int c = 0; c < MAX_COLS; c++) begin
      if (row_in_area && (c < grid_cols_r)) begin
        if (cur_row_r[c*CELL_W +: CELL_W] == CELL_FIRE) begin
          new_row[c*CELL_W +: CELL_W] = CELL_BURNT;
        end else if ((cur_row_r[c*CELL_W +: CELL_W] == CELL_TREE) &&
                     ((up_ok && dn_in && (next_row_r[c*CELL_W +: CELL_W] == CELL_FIRE)) ||
                      (down_ok && up_in && (prev_row_r[c*CELL_W +: CELL_W] == CELL_FIRE)) ||
                      (left_ok && (c + 1 < grid_cols_r) &&
                       (cur_ext[(c+2)*CELL_W +: CELL_W] == CELL_FIRE)) ||
                      (right_ok && (cur_ext[c*CELL_W +: CELL_W] == CELL_FIRE)))) begin
          new_row[c*CELL_W +: CELL_W] = CELL_FIRE;
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    colc_nxt      = colc_r;
    prev_row_nxt  = prev_row_r;
    cur_row_nxt   = cur_row_r;
    next_row_nxt  = next_row_r;
    shift_nxt     = shift_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    item_row_nxt  = item_row_r;
    item_col_nxt  = item_col_r;
    item_val_nxt  = item_val_r;
    rdval_nxt     = rdval_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_rd_nxt    = out_rd_r;
    out_any_nxt   = out_any_r;
    grid_rows_nxt = grid_rows_r;
    grid_cols_nxt = grid_cols_r;
    wind_nxt      = wind_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = row_r;
    mem_raddr     = RAW'(item_row_r);
    mem_wdata     = new_row;

    if (cfg_we) begin
      case (cfg_addr)
        CFG_GRID_ROWS: grid_rows_nxt = cfg_wdata;
        CFG_GRID_COLS: grid_cols_nxt = cfg_wdata;
        CFG_WIND_MODE: wind_nxt      = cfg_wdata[WIND_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (row_r == LAST_ROW) begin
          row_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          row_nxt = row_r + RAW'(1);
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt       = in_op;
          item_row_nxt = in_row;
          item_col_nxt = in_col;
          item_val_nxt = in_val;
          rdval_nxt    = CELL_EMPTY;
          unique case (in_op) inside
            OP_WRITE, OP_READ: begin
              if (in_inside) begin
                mem_re    = 1'b1;
                mem_raddr = RAW'(in_row);
                state_nxt = ST_ACCESS;
              end else begin
                state_nxt = ST_RESULT;
              end
            end
            OP_ADVANCE: begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              row_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = ST_ADV_LD1;
            end
            default: state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_ACCESS: begin
        if (op_r == OP_WRITE) begin
          mem_we    = 1'b1;
          mem_waddr = RAW'(item_row_r);
          mem_wdata = mod_row;
          cnt_nxt   = cnt_r - CNT_W'(old_cell == CELL_FIRE)
                            + CNT_W'(item_val_r == CELL_FIRE);
        end else begin
          rdval_nxt = old_cell;
        end
        state_nxt = ST_RESULT;
      end
      ST_ADV_LD1: begin
        cur_row_nxt = rd_data_r;
        mem_re      = 1'b1;
        mem_raddr   = RAW'(1);
        state_nxt   = ST_ADV_LD2;
      end
      ST_ADV_LD2: begin
        next_row_nxt = rd_data_r;
        state_nxt    = ST_ADV_ROW;
      end
      ST_ADV_ROW: begin
        // Row r is overwritten in place; the window keeps its old value for row r+1.
        mem_we    = 1'b1;
        mem_waddr = row_r;
        mem_wdata = new_row;
        shift_nxt = new_row;
        colc_nxt  = '0;
        if (row_p2 < MAX_ROWS) begin
          mem_re    = 1'b1;
          mem_raddr = row_p2[RAW-1:0];
        end
        state_nxt = ST_ADV_CNT;
      end
      ST_ADV_CNT: begin
        cnt_nxt   = cnt_r + CNT_W'(shift_r[CELL_W-1:0] == CELL_FIRE);
        shift_nxt = shift_r >> CELL_W;
        colc_nxt  = colc_r + CAW'(1);
        if (colc_r == LAST_COL) begin
          prev_row_nxt = cur_row_r;
          cur_row_nxt  = next_row_r;
          next_row_nxt = rd_data_r;
          if (row_r == LAST_ROW) begin
            state_nxt = ST_RESULT;
          end else begin
            row_nxt   = row_r + RAW'(1);
            state_nxt = ST_ADV_ROW;
          end
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = rdval_r;
          out_any_nxt   = cnt_r != '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= grid_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      row_r       <= '0;
      colc_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      grid_rows_r <= RST_GRID_ROWS;
      grid_cols_r <= RST_GRID_COLS;
      wind_r      <= RST_WIND_MODE;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      colc_r      <= colc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      grid_rows_r <= grid_rows_nxt;
      grid_cols_r <= grid_cols_nxt;
      wind_r      <= wind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_row_r <= prev_row_nxt;
    cur_row_r  <= cur_row_nxt;
    next_row_r <= next_row_nxt;
    shift_r    <= shift_nxt;
    op_r       <= op_nxt;
    item_row_r <= item_row_nxt;
    item_col_r <= item_col_nxt;
    item_val_r <= item_val_nxt;
    rdval_r    <= rdval_nxt;
    out_rd_r   <= out_rd_nxt;
    out_any_r  <= out_any_nxt;
  end

endmodule
